### design/nst_pkg.sv
// Package for the NAT session translator: request and result types, codes.
// No dependencies.
`timescale 1ns / 1ps
package nst_pkg;

  localparam logic [1:0] OP_PACKET = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_SWEEP  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_NEW      = 3'd1;
  localparam logic [2:0] ST_NOT_IPV4 = 3'd2;
  localparam logic [2:0] ST_NOT_L4   = 3'd3;
  localparam logic [2:0] ST_NO_SESS  = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_SWEEP    = 3'd6;

  localparam logic [1:0] REG_EXT_ADDR  = 2'd0;
  localparam logic [1:0] REG_PORT_BASE = 2'd1;
  localparam logic [1:0] REG_PORT_CNT  = 2'd2;
  localparam logic [1:0] REG_TIMEOUT   = 2'd3;

  localparam logic [15:0] ETHER_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  typedef struct packed {
    logic [1:0]  operation;
    logic        from_inside;
    logic [15:0] frame_type;
    logic [7:0]  protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
  } nst_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] new_source_address;
    logic [31:0] new_dest_address;
    logic [15:0] new_source_port;
    logic [15:0] new_dest_port;
    logic [6:0]  removed_count;
  } nst_res_t;

  // Per-entry compare result from the shared scan unit
  typedef struct packed {
    logic key_match;
    logic expired;
  } nst_cmp_t;

endpackage

### design/nst_scan_cmp.sv
// Shared compare unit: key match and age check for one table entry.
// Depends on nst_pkg.
`timescale 1ns / 1ps
module nst_scan_cmp (
  input  logic [31:0]    key_sa,
  input  logic [31:0]    key_da,
  input  logic [31:0]    key_pp,
  input  logic [7:0]     key_pr,
  input  logic [31:0]    created,
  input  nst_pkg::nst_req_t req,
  input  logic [31:0]    time_now,
  input  logic [31:0]    timeout,
  output nst_pkg::nst_cmp_t cmp
);
  import nst_pkg::*;
  logic [31:0] age;
  assign age = time_now - created;
  assign cmp.key_match = (key_sa == req.source_address) && (key_da == req.dest_address) &&
                         (key_pp == {req.source_port, req.dest_port}) &&
                         (key_pr == req.protocol);
  assign cmp.expired = age > timeout;
endmodule

### design/nat_session_translator_unit.sv
// NAT session translator top level: sequencer, session table memory, allocator.
// Depends on nst_pkg and nst_scan_cmp.
// Packet or sweep: the table is scanned with one entry read per cycle, then the result is
// issued; the next request is accepted only after the result has been taken.
// Tick: no result; rejected packet: result issued without a table scan.
// Reset (rst, synchronous): valid bits clear at once, registers take defaults.
`timescale 1ns / 1ps
module nat_session_translator_unit #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  nst_pkg::nst_req_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output nst_pkg::nst_res_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import nst_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] LAST = CW'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_SCAN, S_DECIDE, S_OUT} state_t;
  state_t state;

  logic [31:0] ext_addr, timeout;
  logic [15:0] port_base, port_cnt, next_port;
  logic [31:0] time_now;
  nst_req_t req;
  nst_res_t res;

  // Session table memory
  logic [31:0] m_sa [TABLE_ENTRIES];
  logic [31:0] m_da [TABLE_ENTRIES];
  logic [31:0] m_pp [TABLE_ENTRIES];
  logic [7:0]  m_pr [TABLE_ENTRIES];
  logic [31:0] m_ma [TABLE_ENTRIES];
  logic [15:0] m_mp [TABLE_ENTRIES];
  logic [31:0] m_ct [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;

  logic [31:0] r_sa, r_da, r_pp, r_ma, r_ct;
  logic [7:0]  r_pr;
  logic [15:0] r_mp;
  logic [CW-1:0] rd_idx;   // address issued
  logic [IW-1:0] cmp_idx;  // entry whose data is registered
  logic          cmp_vld;
  logic          hit, have_free;
  logic [IW-1:0] free_idx;
  logic [6:0]    removed;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [15:0]   port_take, port_adv;
  logic [16:0]   port_lim;
  nst_cmp_t      cmp;

  nst_scan_cmp u_cmp (
    .key_sa(r_sa), .key_da(r_da), .key_pp(r_pp), .key_pr(r_pr), .created(r_ct),
    .req(req), .time_now(time_now), .timeout(timeout), .cmp(cmp)
  );

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      m_sa[wr_idx] <= req.source_address;
      m_da[wr_idx] <= req.dest_address;
      m_pp[wr_idx] <= {req.source_port, req.dest_port};
      m_pr[wr_idx] <= req.protocol;
      m_ma[wr_idx] <= ext_addr;
      m_mp[wr_idx] <= port_take;
      m_ct[wr_idx] <= time_now;
    end
    r_sa <= m_sa[rd_idx[IW-1:0]];
    r_da <= m_da[rd_idx[IW-1:0]];
    r_pp <= m_pp[rd_idx[IW-1:0]];
    r_pr <= m_pr[rd_idx[IW-1:0]];
    r_ma <= m_ma[rd_idx[IW-1:0]];
    r_mp <= m_mp[rd_idx[IW-1:0]];
    r_ct <= m_ct[rd_idx[IW-1:0]];
  end

  // Allocator
  always_comb begin
    port_take = (next_port == 16'd0) ? port_base : next_port;
    port_lim  = {1'b0, port_base} + {1'b0, port_cnt};
    port_adv  = port_take + 16'd1;
    if ({1'b0, port_adv} >= port_lim) port_adv = port_base;
  end

  assign wr_en    = (state == S_DECIDE) && req.from_inside && !hit && have_free;
  assign wr_idx   = free_idx;
  assign in_stall = (state != S_IDLE) || rst;
  assign out_data = res;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      valid <= '0;
      ext_addr <= 32'hDEADBEEF;
      port_base <= 16'd30000;
      port_cnt <= 16'd10000;
      timeout <= 32'd300;
      time_now <= '0;
      next_port <= '0;
      rd_idx <= '0;
      cmp_vld <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_EXT_ADDR:  ext_addr <= cfg_data;
          REG_PORT_BASE: port_base <= cfg_data[15:0];
          REG_PORT_CNT:  port_cnt <= cfg_data[15:0];
          REG_TIMEOUT:   timeout <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req <= in_data;
            res <= '0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          hit <= 1'b0;
          have_free <= 1'b0;
          free_idx <= '0;
          removed <= '0;
          rd_idx <= '0;
          cmp_vld <= 1'b0;
          if (req.operation == OP_TICK) begin
            time_now <= time_now + 32'd1;
            state <= S_IDLE;
          end else if (req.operation == OP_SWEEP) begin
            state <= S_SCAN;
          end else if (req.operation == OP_PACKET) begin
            if (req.frame_type != ETHER_IPV4) begin
              res.status <= ST_NOT_IPV4;
              out_valid <= 1'b1;
              state <= S_OUT;
            end else if (req.protocol != PROTO_TCP && req.protocol != PROTO_UDP) begin
              res.status <= ST_NOT_L4;
              out_valid <= 1'b1;
              state <= S_OUT;
            end else begin
              state <= S_SCAN;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          // Issue next read; evaluate entry read last cycle
          if (rd_idx <= LAST) begin
            cmp_idx <= rd_idx[IW-1:0];
            rd_idx <= rd_idx + CW'(1);
            cmp_vld <= 1'b1;
          end else begin
            cmp_vld <= 1'b0;
          end
          if (cmp_vld) begin
            if (req.operation == OP_SWEEP) begin
              if (valid[cmp_idx] && cmp.expired) begin
                valid[cmp_idx] <= 1'b0;
                if (removed != 7'd127) removed <= removed + 7'd1;
              end
            end else begin
              if (valid[cmp_idx] && cmp.key_match && !hit) begin
                hit <= 1'b1;
                res.new_source_address <= req.from_inside ? r_ma : req.source_address;
                res.new_source_port <= req.from_inside ? r_mp : req.source_port;
                res.new_dest_address <= req.from_inside ? req.dest_address : r_sa;
                res.new_dest_port <= req.from_inside ? req.dest_port : r_pp[31:16];
              end
              if (!valid[cmp_idx] && !have_free) begin
                have_free <= 1'b1;
                free_idx <= cmp_idx;
              end
            end
            if (cmp_idx == LAST[IW-1:0]) state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          out_valid <= 1'b1;
          state <= S_OUT;
          if (req.operation == OP_SWEEP) begin
            res.status <= ST_SWEEP;
            res.removed_count <= removed;
          end else if (hit) begin
            res.status <= ST_HIT;
          end else if (!req.from_inside) begin
            res.status <= ST_NO_SESS;
          end else begin
            next_port <= port_adv;
            if (have_free) begin
              valid[free_idx] <= 1'b1;
              res.status <= ST_NEW;
              res.new_source_address <= ext_addr;
              res.new_source_port <= port_take;
              res.new_dest_address <= req.dest_address;
              res.new_dest_port <= req.dest_port;
            end else begin
              res.status <= ST_FULL;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_idle_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT || state == S_IDLE)) else $error("result outside output state");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && out_stall) |=> (state == S_OUT && out_valid))
    else $error("result dropped while stalled");
  a_wr: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !valid[wr_idx]) else $error("write over live entry");
  a_sweep_res: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.status != ST_SWEEP) |-> res.removed_count == 7'd0)
    else $error("count on non-sweep result");
endmodule

### verif/tb.sv
// Testbench for nat_session_translator_unit: random and directed requests checked
// against a behavioral session-table predictor. Depends on nst_pkg and the RTL.
`timescale 1ns / 1ps
module tb;
  import nst_pkg::*;

  localparam int ENTRIES = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  nst_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  nst_res_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  nat_session_translator_unit #(.TABLE_ENTRIES(ENTRIES)) DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Predictor state
  logic [31:0] ext_addr_q, timeout_q;
  logic [15:0] port_base_q, port_cnt_q;
  logic        sess_valid [ENTRIES];
  logic [31:0] sess_sa [ENTRIES];
  logic [31:0] sess_da [ENTRIES];
  logic [31:0] sess_pp [ENTRIES];
  logic [7:0]  sess_proto [ENTRIES];
  logic [31:0] sess_map_addr [ENTRIES];
  logic [15:0] sess_map_port [ENTRIES];
  logic [31:0] sess_born [ENTRIES];
  logic [31:0] clock_ticks;
  logic [15:0] alloc_port;

  nst_req_t request_queue [$];
  nst_res_t translation_queue [$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_receiver = 0;
  bit hold_started = 0;
  int hold_left = 0;

  task automatic reset_predictor();
    ext_addr_q = 32'hDEADBEEF;
    port_base_q = 16'd30000;
    port_cnt_q = 16'd10000;
    timeout_q = 32'd300;
    for (int i = 0; i < ENTRIES; i++) sess_valid[i] = 1'b0;
    clock_ticks = '0;
    alloc_port = '0;
  endtask

  function automatic logic [15:0] next_port();
    logic [15:0] p;
    if (alloc_port == 16'd0) alloc_port = port_base_q;
    p = alloc_port;
    alloc_port = alloc_port + 16'd1;
    if ({1'b0, alloc_port} >= {1'b0, port_base_q} + {1'b0, port_cnt_q})
      alloc_port = port_base_q;
    return p;
  endfunction

  // Returns 1 if the request produces a translation result
  function automatic bit translate(input nst_req_t r, output nst_res_t res);
    int hit, slot;
    logic [31:0] pp;
    logic [15:0] port;
    logic [6:0] n;
    res = '0;
    pp = {r.source_port, r.dest_port};
    if (r.operation == OP_TICK) begin
      clock_ticks = clock_ticks + 32'd1;
      return 0;
    end
    if (r.operation == OP_SWEEP) begin
      n = '0;
      for (int i = 0; i < ENTRIES; i++)
        if (sess_valid[i] && (clock_ticks - sess_born[i]) > timeout_q) begin
          sess_valid[i] = 1'b0;
          if (n < 7'd127) n++;
        end
      res.status = ST_SWEEP;
      res.removed_count = n;
      return 1;
    end
    if (r.operation != OP_PACKET) return 0;
    if (r.frame_type != ETHER_IPV4) begin
      res.status = ST_NOT_IPV4;
      return 1;
    end
    if (r.protocol != PROTO_TCP && r.protocol != PROTO_UDP) begin
      res.status = ST_NOT_L4;
      return 1;
    end
    hit = -1;
    for (int i = ENTRIES - 1; i >= 0; i--)
      if (sess_valid[i] && sess_sa[i] == r.source_address && sess_da[i] == r.dest_address &&
          sess_pp[i] == pp && sess_proto[i] == r.protocol) hit = i;
    if (r.from_inside) begin
      if (hit >= 0) begin
        res.status = ST_HIT;
        res.new_source_address = sess_map_addr[hit];
        res.new_dest_address = r.dest_address;
        res.new_source_port = sess_map_port[hit];
        res.new_dest_port = r.dest_port;
        return 1;
      end
      port = next_port();
      slot = -1;
      for (int i = ENTRIES - 1; i >= 0; i--) if (!sess_valid[i]) slot = i;
      if (slot < 0) begin
        res.status = ST_FULL;
        return 1;
      end
      sess_valid[slot] = 1'b1;
      sess_sa[slot] = r.source_address;
      sess_da[slot] = r.dest_address;
      sess_pp[slot] = pp;
      sess_proto[slot] = r.protocol;
      sess_map_addr[slot] = ext_addr_q;
      sess_map_port[slot] = port;
      sess_born[slot] = clock_ticks;
      res.status = ST_NEW;
      res.new_source_address = ext_addr_q;
      res.new_dest_address = r.dest_address;
      res.new_source_port = port;
      res.new_dest_port = r.dest_port;
      return 1;
    end
    if (hit < 0) begin
      res.status = ST_NO_SESS;
      return 1;
    end
    res.status = ST_HIT;
    res.new_source_address = r.source_address;
    res.new_dest_address = sess_sa[hit];
    res.new_source_port = r.source_port;
    res.new_dest_port = sess_pp[hit][31:16];
    return 1;
  endfunction

  // Request builders
  function automatic nst_req_t make_packet(input bit outbound, input logic [15:0] et,
                                           input logic [7:0] pr);
    nst_req_t r;
    r.operation = OP_PACKET;
    r.from_inside = outbound;
    r.frame_type = et;
    r.protocol = pr;
    r.source_address = $urandom;
    r.dest_address = $urandom;
    r.source_port = 16'($urandom);
    r.dest_port = 16'($urandom);
    return r;
  endfunction

  function automatic nst_req_t make_op(input logic [1:0] op);
    nst_req_t r;
    r = make_packet(1'($urandom_range(0, 1)), 16'($urandom), 8'($urandom));
    r.operation = op;
    return r;
  endfunction

  // Small pool of flows so lookups hit and the table fills
  function automatic nst_req_t make_flow();
    nst_req_t r;
    r = make_packet(1'b1, ETHER_IPV4, $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP);
    r.source_address = {24'h0A0000, 8'($urandom_range(0, 90))};
    r.dest_address = 32'h08080808;
    r.source_port = 16'd1000 + 16'($urandom_range(0, 1));
    r.dest_port = 16'd80;
    return r;
  endfunction

  // Driver: bursts and gaps, payload held while stalled
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (request_queue.size() > 0) begin
        nst_res_t res;
        nst_req_t r;
        r = request_queue.pop_front();
        if (translate(r, res)) translation_queue.push_back(res);
        in_data <= r;
        in_valid <= 1'b1;
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 8);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off counted here
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_receiver && !hold_started) begin
      hold_started <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 7) < 3) && ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (translation_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        nst_res_t e;
        e = translation_queue.pop_front();
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, out_data);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  task automatic wait_drain();
    while (request_queue.size() > 0 || in_valid || translation_queue.size() > 0) @(posedge clk);
    repeat (ENTRIES + 10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_EXT_ADDR:  ext_addr_q = val;
      REG_PORT_BASE: port_base_q = val[15:0];
      REG_PORT_CNT:  port_cnt_q = val[15:0];
      default:       timeout_q = val;
    endcase
  endtask

  task automatic random_phase(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 19))
        0: request_queue.push_back(make_op(OP_SWEEP));
        1, 2, 3: request_queue.push_back(make_op(OP_TICK));
        4: request_queue.push_back(make_op(OP_NONE));
        5: request_queue.push_back(make_packet(1'($urandom_range(0, 1)), 16'($urandom),
                                               8'($urandom)));
        6: request_queue.push_back(make_packet(1'($urandom_range(0, 1)), ETHER_IPV4,
                                               8'($urandom)));
        7, 8, 9: begin
          nst_req_t r;
          r = make_flow();
          r.from_inside = 1'b0;
          request_queue.push_back(r);
        end
        default: request_queue.push_back(make_flow());
      endcase
    end
  endtask

  initial begin
    nst_req_t r;
    reset_predictor();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: rejects, field extremes, new/hit/inbound, ignored op, tick, sweep
    request_queue.push_back(make_packet(1'b1, 16'hFFFF, PROTO_TCP));
    request_queue.push_back(make_packet(1'b0, 16'h0000, PROTO_UDP));
    request_queue.push_back(make_packet(1'b1, ETHER_IPV4, 8'hFF));
    request_queue.push_back(make_packet(1'b0, ETHER_IPV4, 8'h00));
    r = make_packet(1'b1, ETHER_IPV4, PROTO_TCP);
    r.source_address = '1; r.dest_address = '1; r.source_port = '1; r.dest_port = '1;
    request_queue.push_back(r);
    request_queue.push_back(r);
    r = make_packet(1'b1, ETHER_IPV4, PROTO_UDP);
    r.source_address = '0; r.dest_address = '0; r.source_port = '0; r.dest_port = '0;
    request_queue.push_back(r);
    r.from_inside = 1'b0;
    request_queue.push_back(r);
    request_queue.push_back(make_packet(1'b0, ETHER_IPV4, PROTO_TCP));
    request_queue.push_back(make_op(OP_NONE));
    request_queue.push_back(make_op(OP_TICK));
    request_queue.push_back(make_op(OP_SWEEP));
    wait_drain();

    // Small range and zero timeout: port wrap, aging
    write_reg(REG_EXT_ADDR, 32'h00000000);
    write_reg(REG_PORT_BASE, 32'd65533);
    write_reg(REG_PORT_CNT, 32'd3);
    write_reg(REG_TIMEOUT, 32'd0);
    random_phase(120);
    wait_drain();

    // Fill the table with a long receiver hold-off
    write_reg(REG_EXT_ADDR, 32'hFFFFFFFF);
    write_reg(REG_PORT_BASE, 32'd1);
    write_reg(REG_PORT_CNT, 32'd65535);
    write_reg(REG_TIMEOUT, 32'hFFFFFFFF);
    for (int k = 0; k < 80; k++) request_queue.push_back(make_flow());
    hold_receiver = 1'b1;
    wait (hold_started && hold_left == 0);
    hold_receiver = 1'b0;
    random_phase(110);
    wait_drain();

    // Default-like settings, long run
    write_reg(REG_EXT_ADDR, $urandom);
    write_reg(REG_PORT_BASE, 32'd30000);
    write_reg(REG_PORT_CNT, 32'd10);
    write_reg(REG_TIMEOUT, 32'd5);
    random_phase(150);
    wait_drain();

    if (mismatches == 0 && translation_queue.size() == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule

### files.f
design/nst_pkg.sv
design/nst_scan_cmp.sv
design/nat_session_translator_unit.sv
verif/tb.sv
